// ----- sv/reorder_buffer_selective_ack_assert.svh -----
// Assertion macros for the reorder buffer with selective acknowledgement.
// Included by the top level; depends on nothing else.
`ifndef REORDER_BUFFER_SELECTIVE_ACK_ASSERT_SVH
`define REORDER_BUFFER_SELECTIVE_ACK_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define RBSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define RBSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/rbsa_pkg.sv -----
// Package of the reorder buffer with selective acknowledgement: types, codes
// and constants shared by the store, the result stage and the top level.
package rbsa_pkg;

   localparam int unsigned REORDER_DEPTH_DEF = 32;
   localparam int unsigned ACK_ENTRIES_DEF = 16;
   localparam int unsigned SEQ_W = 31;
   localparam int unsigned ACK_EVERY = 10;
   localparam int unsigned ACK_REPEAT_MAX = 3;
   localparam int unsigned IDLE_LIMIT = 20;
   localparam int unsigned TIMER_TRIM = 5;
   localparam logic [15:0] ACK_TIMER_RESET = 16'd20;
   localparam logic [15:0] MAX_WINDOW_RESET = 16'd1024;

   localparam logic [1:0] CMD_PACKET = 2'd0;
   localparam logic [1:0] CMD_TIMER = 2'd1;
   localparam logic [1:0] CMD_WINDOW = 2'd2;

   localparam logic CSR_ACK_TIMER = 1'b0;
   localparam logic CSR_MAX_WINDOW = 1'b1;

   localparam logic [2:0] KIND_DELIVER = 3'd0;
   localparam logic [2:0] KIND_DROP_DUP = 3'd1;
   localparam logic [2:0] KIND_ACK_ENTRY = 3'd2;
   localparam logic [2:0] KIND_ACK_SUMMARY = 3'd3;
   localparam logic [2:0] KIND_DROP_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [30:0] seq_num;
      logic [15:0] buf_handle;
      logic [31:0] now_us;
      logic [31:0] now_ms;
      logic [15:0] cached_blocks;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [15:0] out_handle;
      logic [30:0] out_seq;
      logic [31:0] wait_time_us;
      logic [30:0] ack_low_line;
      logic [15:0] window_free;
      logic [31:0] ack_serial;
      logic [31:0] dup_count;
      logic [4:0] entry_count;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic [1:0] ack_times;
      logic [31:0] arrival_us;
      logic [15:0] handle;
   } slot_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      slot_type wr_word;
   } store_ctl_type;

   typedef struct packed {
      logic push;
      logic flush;
   } emit_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PKT,
      ST_AHEAD,
      ST_DRAIN_RD,
      ST_DRAIN_CHK,
      ST_POST,
      ST_TMR_MUL,
      ST_TMR_CMP,
      ST_ACK_START,
      ST_ACK_RD,
      ST_ACK_CHK,
      ST_ACK_FB,
      ST_ACK_SUM,
      ST_FINISH
   } state_type;

endpackage

// ----- sv/rbsa_store.sv -----
// Reorder store: one slot per window position, one read and one write a cycle.
// Clears itself after reset. Depends on rbsa_pkg.
module rbsa_store #(
   parameter int unsigned DEPTH = rbsa_pkg::REORDER_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input rbsa_pkg::store_ctl_type ctl,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   output rbsa_pkg::slot_type rd_word,
   output logic init_done
);
   localparam int unsigned AW = $clog2(DEPTH);

   rbsa_pkg::slot_type mem [DEPTH];
   rbsa_pkg::slot_type rd_word_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic done_ff;
   logic done_in;
   logic wr_en;
   logic [AW-1:0] wr_sel;
   rbsa_pkg::slot_type wr_data;

   always_comb begin
      clr_in = clr_ff;
      done_in = done_ff;
      if (!done_ff) begin
         if (clr_ff == AW'(DEPTH - 1)) begin
            done_in = 1'b1;
         end else begin
            clr_in = clr_ff + AW'(1);
         end
      end
      wr_en = done_ff ? ctl.wr_en : 1'b1;
      wr_sel = done_ff ? wr_addr : clr_ff;
      wr_data = done_ff ? ctl.wr_word : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_sel] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_word = rd_word_ff;
   assign init_done = done_ff;
endmodule

// ----- sv/rbsa_emit.sv -----
// Result stage: holds one result back until it is known whether it is the last
// of its transaction, then presents it for one cycle. Depends on rbsa_pkg.
module rbsa_emit (
   input logic clock,
   input logic reset,
   input rbsa_pkg::emit_ctl_type ctl,
   input rbsa_pkg::rsp_type item,
   output logic rsp_strobe,
   output rbsa_pkg::rsp_type rsp_data,
   output logic pend_valid
);
   logic pend_valid_ff;
   logic pend_valid_in;
   rbsa_pkg::rsp_type pend_ff;
   rbsa_pkg::rsp_type pend_in;
   logic strobe_ff;
   logic strobe_in;
   rbsa_pkg::rsp_type out_ff;
   rbsa_pkg::rsp_type out_in;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      strobe_in = 1'b0;
      out_in = out_ff;
      if (ctl.push) begin
         if (pend_valid_ff) begin
            strobe_in = 1'b1;
            out_in = pend_ff;
            out_in.last = 1'b0;
         end
         pend_in = item;
         pend_valid_in = 1'b1;
      end else if (ctl.flush && pend_valid_ff) begin
         strobe_in = 1'b1;
         out_in = pend_ff;
         out_in.last = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = out_ff;
   assign pend_valid = pend_valid_ff;
endmodule

// ----- sv/reorder_buffer_selective_ack.sv -----
// Top level of the reorder buffer with selective acknowledgement: sequencer,
// link state and configuration. Depends on rbsa_pkg, rbsa_store, rbsa_emit.
//
// A transaction is taken when start is high and busy is low. Command 0 is a
// data packet, command 1 an ack timer tick, command 2 a window update and
// command 3 is ignored. Window updates and ignored commands finish in the
// cycle they are taken. Results appear on rsp_data for one cycle each,
// marked by rsp_strobe; the final result of a transaction carries last.
// The receiver cannot hold results off.
// A dropped packet goes from ST_PKT to ST_POST, a stored one writes its slot
// in ST_AHEAD, and one in order drains the stored packets behind it through
// ST_DRAIN_RD and ST_DRAIN_CHK; an ack message walks up to REORDER_DEPTH - 1
// store slots through ST_ACK_RD and ST_ACK_CHK. A timer tick sends an ack
// only when the timer fires. Store reads are registered, so each read and
// its check take separate states. After reset the store is cleared one slot
// a cycle, with busy high; configuration writes are taken at any time.
module reorder_buffer_selective_ack #(
   parameter int unsigned REORDER_DEPTH = rbsa_pkg::REORDER_DEPTH_DEF,
   parameter int unsigned ACK_ENTRIES = rbsa_pkg::ACK_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input rbsa_pkg::req_type req_data,
   output logic rsp_strobe,
   output rbsa_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic csr_index,
   input logic [15:0] csr_wdata
);
   `include "reorder_buffer_selective_ack_assert.svh"

   localparam int unsigned AW = $clog2(REORDER_DEPTH);
   localparam int unsigned CW = $clog2(ACK_ENTRIES + 1);
   localparam logic [AW:0] DEPTH_X = (AW + 1)'(REORDER_DEPTH);

   rbsa_pkg::state_type state_ff;
   rbsa_pkg::state_type state_in;

   rbsa_pkg::req_type req_ff;
   logic [15:0] timer_ff;
   logic [15:0] maxwin_ff;
   logic [30:0] low_ff;
   logic [30:0] low_in;
   logic [AW-1:0] base_ff;
   logic [AW-1:0] base_in;
   logic [3:0] unacked_ff;
   logic [3:0] unacked_in;
   logic [30:0] last_seq_ff;
   logic [30:0] last_seq_in;
   logic [31:0] last_arr_ff;
   logic [31:0] last_arr_in;
   logic last_valid_ff;
   logic last_valid_in;
   logic [31:0] last_ack_ms_ff;
   logic [31:0] last_ack_ms_in;
   logic [4:0] idle_ff;
   logic [4:0] idle_in;
   logic [30:0] prev_low_ff;
   logic [30:0] prev_low_in;
   logic [31:0] ack_ctr_ff;
   logic [31:0] ack_ctr_in;
   logic [31:0] dup_ff;
   logic [31:0] dup_in;
   logic [15:0] fw_ff;
   logic [15:0] fw_in;
   logic [31:0] span_ff;
   logic [31:0] span_in;
   logic [AW-1:0] ack_d_ff;
   logic [AW-1:0] ack_d_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;

   logic accept;
   logic init_done;
   logic pend_valid;
   logic [30:0] pkt_d;
   logic [AW:0] pkt_sum;
   logic [AW-1:0] pkt_idx;
   logic [AW:0] ack_sum;
   logic [AW-1:0] ack_idx;
   logic [AW-1:0] base_next;
   logic [15:0] fw_dec;
   logic ack_hit;
   logic [CW-1:0] cnt_hit;
   logic [31:0] tmr_diff;
   logic tmr_fire;

   rbsa_pkg::store_ctl_type st_ctl;
   logic [AW-1:0] st_rd_addr;
   logic [AW-1:0] st_wr_addr;
   rbsa_pkg::slot_type st_rd_word;
   rbsa_pkg::emit_ctl_type em_ctl;
   rbsa_pkg::rsp_type em_item;

   rbsa_store #(.DEPTH(REORDER_DEPTH)) u_store (
      .clock(clock),
      .reset(reset),
      .ctl(st_ctl),
      .rd_addr(st_rd_addr),
      .wr_addr(st_wr_addr),
      .rd_word(st_rd_word),
      .init_done(init_done)
   );

   rbsa_emit u_emit (
      .clock(clock),
      .reset(reset),
      .ctl(em_ctl),
      .item(em_item),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .pend_valid(pend_valid)
   );

   assign busy = (state_ff != rbsa_pkg::ST_IDLE) || !init_done;
   assign accept = start && !busy;

   always_comb begin
      pkt_d = req_ff.seq_num - low_ff;
      pkt_sum = {1'b0, base_ff} + {1'b0, pkt_d[AW-1:0]};
      pkt_idx = (pkt_sum >= DEPTH_X) ? AW'(pkt_sum - DEPTH_X) : pkt_sum[AW-1:0];
      ack_sum = {1'b0, base_ff} + {1'b0, ack_d_ff};
      ack_idx = (ack_sum >= DEPTH_X) ? AW'(ack_sum - DEPTH_X) : ack_sum[AW-1:0];
      base_next = (base_ff == AW'(REORDER_DEPTH - 1)) ? '0 : base_ff + AW'(1);
      fw_dec = (fw_ff != 16'd0) ? fw_ff - 16'd1 : fw_ff;
      ack_hit = st_rd_word.valid && (st_rd_word.ack_times < 2'(rbsa_pkg::ACK_REPEAT_MAX));
      cnt_hit = ack_hit ? cnt_ff + CW'(1) : cnt_ff;
      tmr_diff = req_ff.now_ms - (last_ack_ms_ff + span_ff);
      tmr_fire = (tmr_diff != 32'd0) && !tmr_diff[31]
         && (idle_ff < 5'(rbsa_pkg::IDLE_LIMIT));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbsa_pkg::ST_IDLE: begin
            if (accept && req_data.cmd == rbsa_pkg::CMD_PACKET) begin
               state_in = rbsa_pkg::ST_PKT;
            end else if (accept && req_data.cmd == rbsa_pkg::CMD_TIMER) begin
               state_in = rbsa_pkg::ST_TMR_MUL;
            end
         end
         rbsa_pkg::ST_PKT: begin
            priority if (pkt_d == 31'd0) begin
               state_in = rbsa_pkg::ST_DRAIN_RD;
            end else if (!pkt_d[30] && pkt_d < 31'(REORDER_DEPTH)) begin
               state_in = rbsa_pkg::ST_AHEAD;
            end else begin
               state_in = rbsa_pkg::ST_POST;
            end
         end
         rbsa_pkg::ST_AHEAD: state_in = rbsa_pkg::ST_POST;
         rbsa_pkg::ST_DRAIN_RD: state_in = rbsa_pkg::ST_DRAIN_CHK;
         rbsa_pkg::ST_DRAIN_CHK: begin
            state_in = st_rd_word.valid ? rbsa_pkg::ST_DRAIN_RD : rbsa_pkg::ST_POST;
         end
         rbsa_pkg::ST_POST: begin
            state_in = (unacked_ff >= 4'(rbsa_pkg::ACK_EVERY)) ?
               rbsa_pkg::ST_ACK_START : rbsa_pkg::ST_FINISH;
         end
         rbsa_pkg::ST_TMR_MUL: state_in = rbsa_pkg::ST_TMR_CMP;
         rbsa_pkg::ST_TMR_CMP: begin
            state_in = tmr_fire ? rbsa_pkg::ST_ACK_START : rbsa_pkg::ST_FINISH;
         end
         rbsa_pkg::ST_ACK_START: state_in = rbsa_pkg::ST_ACK_RD;
         rbsa_pkg::ST_ACK_RD: state_in = rbsa_pkg::ST_ACK_CHK;
         rbsa_pkg::ST_ACK_CHK: begin
            if (ack_d_ff == AW'(REORDER_DEPTH - 1) || cnt_hit == CW'(ACK_ENTRIES)) begin
               state_in = rbsa_pkg::ST_ACK_FB;
            end else begin
               state_in = rbsa_pkg::ST_ACK_RD;
            end
         end
         rbsa_pkg::ST_ACK_FB: state_in = rbsa_pkg::ST_ACK_SUM;
         rbsa_pkg::ST_ACK_SUM: state_in = rbsa_pkg::ST_FINISH;
         rbsa_pkg::ST_FINISH: state_in = rbsa_pkg::ST_IDLE;
         default: state_in = rbsa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      low_in = low_ff;
      base_in = base_ff;
      unacked_in = unacked_ff;
      last_seq_in = last_seq_ff;
      last_arr_in = last_arr_ff;
      last_valid_in = last_valid_ff;
      last_ack_ms_in = last_ack_ms_ff;
      idle_in = idle_ff;
      prev_low_in = prev_low_ff;
      ack_ctr_in = ack_ctr_ff;
      dup_in = dup_ff;
      fw_in = fw_ff;
      span_in = span_ff;
      ack_d_in = ack_d_ff;
      cnt_in = cnt_ff;
      st_ctl = '0;
      st_rd_addr = '0;
      st_wr_addr = '0;
      em_ctl = '0;
      em_item = '0;
      unique case (state_ff)
         rbsa_pkg::ST_IDLE: begin
            if (accept && req_data.cmd == rbsa_pkg::CMD_WINDOW) begin
               fw_in = (maxwin_ff > req_data.cached_blocks) ?
                  maxwin_ff - req_data.cached_blocks : 16'd0;
               idle_in = '0;
            end
         end
         rbsa_pkg::ST_PKT: begin
            if (unacked_ff < 4'd15) begin
               unacked_in = unacked_ff + 4'd1;
            end
            last_seq_in = req_ff.seq_num;
            last_arr_in = req_ff.now_us;
            last_valid_in = 1'b1;
            em_item.out_handle = req_ff.buf_handle;
            em_item.out_seq = req_ff.seq_num;
            priority if (pkt_d == 31'd0) begin
               em_ctl.push = 1'b1;
               em_item.kind = rbsa_pkg::KIND_DELIVER;
               fw_in = fw_dec;
               low_in = low_ff + 31'd1;
               base_in = base_next;
            end else if (!pkt_d[30]) begin
               if (pkt_d >= 31'(REORDER_DEPTH)) begin
                  em_ctl.push = 1'b1;
                  em_item.kind = rbsa_pkg::KIND_DROP_OVERFLOW;
               end else begin
                  st_ctl.rd_en = 1'b1;
                  st_rd_addr = pkt_idx;
               end
            end else begin
               em_ctl.push = 1'b1;
               em_item.kind = rbsa_pkg::KIND_DROP_DUP;
               dup_in = dup_ff + 32'd1;
            end
         end
         rbsa_pkg::ST_AHEAD: begin
            st_ctl.wr_en = 1'b1;
            st_wr_addr = pkt_idx;
            st_ctl.wr_word.valid = 1'b1;
            st_ctl.wr_word.ack_times = 2'd0;
            st_ctl.wr_word.arrival_us = req_ff.now_us;
            if (st_rd_word.valid) begin
               st_ctl.wr_word.handle = st_rd_word.handle;
               dup_in = dup_ff + 32'd1;
               em_ctl.push = 1'b1;
               em_item.kind = rbsa_pkg::KIND_DROP_DUP;
               em_item.out_handle = req_ff.buf_handle;
               em_item.out_seq = req_ff.seq_num;
            end else begin
               st_ctl.wr_word.handle = req_ff.buf_handle;
            end
         end
         rbsa_pkg::ST_DRAIN_RD: begin
            st_ctl.rd_en = 1'b1;
            st_rd_addr = base_ff;
         end
         rbsa_pkg::ST_DRAIN_CHK: begin
            if (st_rd_word.valid) begin
               st_ctl.wr_en = 1'b1;
               st_wr_addr = base_ff;
               em_ctl.push = 1'b1;
               em_item.kind = rbsa_pkg::KIND_DELIVER;
               em_item.out_handle = st_rd_word.handle;
               em_item.out_seq = low_ff;
               fw_in = fw_dec;
               low_in = low_ff + 31'd1;
               base_in = base_next;
            end
         end
         rbsa_pkg::ST_POST: begin
         end
         rbsa_pkg::ST_TMR_MUL: begin
            span_in = 32'(32'(timer_ff) * 32'({1'b0, idle_ff} + 6'd1))
               - 32'(rbsa_pkg::TIMER_TRIM);
         end
         rbsa_pkg::ST_TMR_CMP: begin
         end
         rbsa_pkg::ST_ACK_START: begin
            last_ack_ms_in = req_ff.now_ms;
            unacked_in = '0;
            ack_d_in = AW'(1);
            cnt_in = '0;
         end
         rbsa_pkg::ST_ACK_RD: begin
            st_ctl.rd_en = 1'b1;
            st_rd_addr = ack_idx;
         end
         rbsa_pkg::ST_ACK_CHK: begin
            if (ack_hit) begin
               st_ctl.wr_en = 1'b1;
               st_wr_addr = ack_idx;
               st_ctl.wr_word = st_rd_word;
               st_ctl.wr_word.ack_times = st_rd_word.ack_times + 2'd1;
               em_ctl.push = 1'b1;
               em_item.kind = rbsa_pkg::KIND_ACK_ENTRY;
               em_item.out_seq = low_ff + 31'(ack_d_ff);
               em_item.wait_time_us = req_ff.now_us - st_rd_word.arrival_us;
               em_item.ack_serial = ack_ctr_ff;
            end
            cnt_in = cnt_hit;
            ack_d_in = ack_d_ff + AW'(1);
         end
         rbsa_pkg::ST_ACK_FB: begin
            if (cnt_ff == '0 && last_valid_ff) begin
               em_ctl.push = 1'b1;
               em_item.kind = rbsa_pkg::KIND_ACK_ENTRY;
               em_item.out_seq = last_seq_ff;
               em_item.wait_time_us = req_ff.now_us - last_arr_ff;
               em_item.ack_serial = ack_ctr_ff;
               cnt_in = CW'(1);
            end
         end
         rbsa_pkg::ST_ACK_SUM: begin
            if (prev_low_ff == low_ff && cnt_ff == '0) begin
               if (idle_ff != 5'd31) begin
                  idle_in = idle_ff + 5'd1;
               end
            end else begin
               idle_in = '0;
            end
            prev_low_in = low_ff;
            em_ctl.push = 1'b1;
            em_item.kind = rbsa_pkg::KIND_ACK_SUMMARY;
            em_item.ack_low_line = low_ff;
            em_item.window_free = fw_ff;
            em_item.ack_serial = ack_ctr_ff;
            em_item.dup_count = dup_ff;
            em_item.entry_count = 5'(cnt_ff);
            ack_ctr_in = ack_ctr_ff + 32'd1;
         end
         rbsa_pkg::ST_FINISH: begin
            em_ctl.flush = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbsa_pkg::ST_IDLE;
         timer_ff <= rbsa_pkg::ACK_TIMER_RESET;
         maxwin_ff <= rbsa_pkg::MAX_WINDOW_RESET;
         low_ff <= '0;
         base_ff <= '0;
         unacked_ff <= '0;
         last_seq_ff <= '0;
         last_arr_ff <= '0;
         last_valid_ff <= 1'b0;
         last_ack_ms_ff <= '0;
         idle_ff <= '0;
         prev_low_ff <= '0;
         ack_ctr_ff <= '0;
         dup_ff <= '0;
         fw_ff <= '0;
         ack_d_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == rbsa_pkg::CSR_ACK_TIMER) begin
            timer_ff <= csr_wdata;
         end
         if (csr_we && csr_index == rbsa_pkg::CSR_MAX_WINDOW) begin
            maxwin_ff <= csr_wdata;
         end
         low_ff <= low_in;
         base_ff <= base_in;
         unacked_ff <= unacked_in;
         last_seq_ff <= last_seq_in;
         last_arr_ff <= last_arr_in;
         last_valid_ff <= last_valid_in;
         last_ack_ms_ff <= last_ack_ms_in;
         idle_ff <= idle_in;
         prev_low_ff <= prev_low_in;
         ack_ctr_ff <= ack_ctr_in;
         dup_ff <= dup_in;
         fw_ff <= fw_in;
         ack_d_ff <= ack_d_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      span_ff <= span_in;
   end

   `RBSA_ASSERT_NEXT(a_packet_busy, clock, reset,
      accept && req_data.cmd == rbsa_pkg::CMD_PACKET, busy,
      "packet transaction did not occupy the sequencer")
   `RBSA_ASSERT_NEXT(a_last_alone, clock, reset,
      rsp_strobe && rsp_data.last, !rsp_strobe,
      "result followed the final result of a transaction")
   `RBSA_ASSERT_SAME(a_idle_empty, clock, reset,
      state_ff == rbsa_pkg::ST_IDLE, !pend_valid,
      "result left pending while idle")
endmodule
